### sv/ptt_pkg.sv
// Shared types and constants for the page table translation block.
package ptt_pkg;

    localparam int KEY_W      = 32;
    localparam int BASE_W     = 32;
    localparam int LEN_W      = 32;
    localparam int LIN_W      = 32;
    localparam int ADDR_OUT_W = 32;
    localparam int CNT_W      = 9;
    localparam int SLOT_W     = 9;
    localparam int PB_W       = 21;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_KEY_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LOOKUP_RANGE = 3'd6;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_ENTRIES = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_PAGE_BYTES    = 1'b1;
    localparam logic [CNT_W-1:0] TABLE_ENTRIES_RST = 9'd256;
    localparam logic [PB_W-1:0]  PAGE_BYTES_RST    = 21'd4096;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] slot_key;
        logic [BASE_W-1:0] page_base;
        logic [LEN_W-1:0] page_len;
        logic [LIN_W-1:0] linear_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_OUT_W-1:0] address;
        logic [CNT_W-1:0] entry_count;
        logic is_full;
        logic tbl_empty;
    } t_rsp;

    typedef struct packed {
        logic [CNT_W-1:0] ents;
        logic [PB_W-1:0] page_bytes;
    } t_cfg;

    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [BASE_W-1:0] page_base;
        logic [LIN_W-1:0] linear_index;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic [LIN_W-1:0] quotient;
        logic [PB_W-1:0] remainder;
    } t_div_res;

endpackage

### sv/page_table_translate.sv
// Top level of the single-level page table with insert, remove and lookup.
//
// Requests: drive i_req and raise start; the word is taken at a rising edge with
// start high and busy low. Up to two words queue behind the one in progress.
// Results: o_rsp is valid for exactly one cycle with o_rsp_valid; take it then.
// Results come back in request order, one per request.
// Steps after acceptance:
//   failed checks and undefined requests: result registered when taken from the queue;
//   insert and remove: store read, then update;
//   lookup: the serial divider (one quotient bit per cycle, 32 bits), then the
//   store read.
// The back end takes the next queued request only once the previous one is done.
// Configuration: APB registers table_entries at 0x0 and page_bytes at 0x4; write
// only while no request is outstanding.
// Reset: clears counts and flags, then a clearing pass zeroes the store at one
// entry per cycle, all DEPTH entries, with busy held high.
// The receiver cannot stall results.
module page_table_translate import ptt_pkg::*; #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_rsp_valid,
    output t_rsp               o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CNT_W-1:0]     r_table_entries;
    logic [PB_W-1:0]      r_page_bytes;
    logic [REG_IDX_W-1:0] reg_idx;
    t_cfg                 cfg;
    logic                 hold;
    logic                 clearing;
    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;
    t_cmd                 front_cmd;
    t_cmd                 head_cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= TABLE_ENTRIES_RST;
            r_page_bytes    <= PAGE_BYTES_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_TABLE_ENTRIES: r_table_entries <= pwdata[CNT_W-1:0];
                REG_PAGE_BYTES:    r_page_bytes    <= pwdata[PB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TABLE_ENTRIES: prdata = PDATA_W'(r_table_entries);
            REG_PAGE_BYTES:    prdata = PDATA_W'(r_page_bytes);
            default:           prdata = '0;
        endcase
    end

    assign cfg.ents = (32'(r_table_entries) > DEPTH) ? CNT_W'(DEPTH) : r_table_entries;
    assign cfg.page_bytes = r_page_bytes;
    assign hold = clearing | ~i_rst_n;

    ptt_front u_front (
        .i_start  (start),
        .i_hold   (hold),
        .i_q_full (q_full),
        .i_req    (i_req),
        .i_cfg    (cfg),
        .o_busy   (busy),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    ptt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (head_cmd)
    );

    ptt_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

### sv/ptt_front.sv
// Front end: accepts request words and classifies them before queueing.
module ptt_front import ptt_pkg::*; (
    input  logic i_start,
    input  logic i_hold,
    input  logic i_q_full,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output logic o_busy,
    output logic o_push,
    output t_cmd o_cmd
);

    logic key_out;

    assign o_busy  = i_hold | i_q_full;
    assign o_push  = i_start & ~o_busy;
    assign key_out = i_req.slot_key >= KEY_W'(i_cfg.ents);

    always_comb begin
        o_cmd.op           = i_req.req_type;
        o_cmd.slot         = SLOT_W'(i_req.slot_key);
        o_cmd.page_base    = i_req.page_base;
        o_cmd.linear_index = i_req.linear_index;
        o_cmd.status       = ST_OK;
        unique case (i_req.req_type)
            REQ_INSERT: begin
                if (key_out) begin
                    o_cmd.status = ST_KEY_RANGE;
                end else if (i_req.page_len != LEN_W'(i_cfg.page_bytes)) begin
                    o_cmd.status = ST_BAD_SIZE;
                end else if (i_req.page_base == '0) begin
                    o_cmd.status = ST_NULL;
                end
            end
            REQ_REMOVE: begin
                if (key_out) begin
                    o_cmd.status = ST_KEY_RANGE;
                end
            end
            REQ_LOOKUP: begin
                if (i_cfg.page_bytes == '0) begin
                    o_cmd.status = ST_LOOKUP_RANGE;
                end
            end
            default: begin
                o_cmd.status = ST_OK;
            end
        endcase
    end

endmodule

### sv/ptt_fifo.sv
// Two-entry command queue between the front end and the back end.
module ptt_fifo import ptt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_rdata
);

    t_cmd               r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_wdata;
        end
    end

endmodule

### sv/ptt_div.sv
// Restoring serial divider: one quotient bit per cycle.
module ptt_div import ptt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [LIN_W-1:0] i_dividend,
    input  logic [PB_W-1:0]  i_divisor,
    output t_div_res         o_res
);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LIN_W-1:0]     r_quo;
    logic [PB_W-1:0]      r_rem;
    logic [PB_W-1:0]      r_dvs;

    logic [PB_W:0]   shifted;
    logic [PB_W:0]   diff;
    logic            ge;
    logic [PB_W-1:0] n_rem;

    assign shifted = {r_rem, r_quo[LIN_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign n_rem   = ge ? diff[PB_W-1:0] : shifted[PB_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_dividend;
                r_rem <= '0;
                r_dvs <= i_divisor;
            end else if (r_run) begin
                r_quo <= {r_quo[LIN_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

### sv/ptt_back.sv
// Back end: base store, clearing pass, lookup divide and result register.
module ptt_back import ptt_pkg::*; #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_clearing,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = (ADDR_W < ADDR_OUT_W) ? ADDR_W : ADDR_OUT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_EXEC
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_clr_idx;
    logic [IDX_W-1:0]    r_idx;
    t_cmd                r_cmd;
    logic [PB_W-1:0]     r_off;
    logic [CNT_W-1:0]    r_count;
    logic                r_rsp_valid;
    t_rsp                r_rsp;
    logic [BASE_W-1:0]   r_rdata;
    logic [BASE_W-1:0]   r_mem [DEPTH];

    t_div_res            div_res;
    logic                div_start;
    logic                occupied;
    logic [BASE_W:0]     sum;
    logic [ADDR_OUT_W-1:0] lookup_addr;
    logic [STATUS_W-1:0] exec_status;
    logic [ADDR_OUT_W-1:0] exec_addr;
    logic [CNT_W-1:0]    n_count;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_widx;
    logic [BASE_W-1:0]   mem_wdata;

    function automatic t_rsp make_rsp(input logic [STATUS_W-1:0] st,
                                      input logic [ADDR_OUT_W-1:0] ad,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [CNT_W-1:0] ents);
        t_rsp rsp;
        rsp.status      = st;
        rsp.address     = ad;
        rsp.entry_count = cnt;
        rsp.is_full     = cnt == ents;
        rsp.tbl_empty   = cnt == '0;
        return rsp;
    endfunction

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing = r_state == S_CLEAR;
    assign div_start  = o_pop && (i_cmd.op == REQ_LOOKUP) && (i_cmd.status == ST_OK);

    ptt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cmd.linear_index),
        .i_divisor  (i_cfg.page_bytes),
        .o_res      (div_res)
    );

    assign occupied    = r_rdata != '0;
    assign sum         = {1'b0, r_rdata} + (BASE_W + 1)'(r_off);
    assign lookup_addr = ADDR_OUT_W'(SUM_W'(sum));

    always_comb begin
        exec_status = ST_OK;
        exec_addr   = '0;
        n_count     = r_count;
        mem_we      = 1'b0;
        mem_widx    = r_idx;
        mem_wdata   = '0;
        if (r_state == S_CLEAR) begin
            mem_we   = 1'b1;
            mem_widx = r_clr_idx;
        end else if (r_state == S_EXEC) begin
            case (r_cmd.op)
                REQ_INSERT: begin
                    if (occupied) begin
                        exec_status = ST_OCCUPIED;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = r_cmd.page_base;
                        n_count   = r_count + 1'b1;
                    end
                end
                REQ_REMOVE: begin
                    if (!occupied) begin
                        exec_status = ST_EMPTY;
                    end else begin
                        exec_addr = r_rdata;
                        mem_we    = 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                end
                default: begin
                    exec_addr = lookup_addr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_widx] <= mem_wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_cmd;
                        r_idx <= IDX_W'(i_cmd.slot);
                        if (i_cmd.status != ST_OK) begin
                            r_rsp_valid <= 1'b1;
                            r_rsp <= make_rsp(i_cmd.status, '0, r_count, i_cfg.ents);
                        end else begin
                            case (i_cmd.op) inside
                                REQ_INSERT, REQ_REMOVE: begin
                                    r_state <= S_READ;
                                end
                                REQ_LOOKUP: begin
                                    r_state <= S_DIV;
                                end
                                default: begin
                                    r_rsp_valid <= 1'b1;
                                    r_rsp <= make_rsp(ST_OK, '0, r_count, i_cfg.ents);
                                end
                            endcase
                        end
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        if (div_res.quotient >= LIN_W'(i_cfg.ents)) begin
                            r_state     <= S_IDLE;
                            r_rsp_valid <= 1'b1;
                            r_rsp <= make_rsp(ST_LOOKUP_RANGE, '0, r_count, i_cfg.ents);
                        end else begin
                            r_idx   <= IDX_W'(div_res.quotient);
                            r_off   <= div_res.remainder;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_count     <= n_count;
                    r_rsp_valid <= 1'b1;
                    r_rsp <= make_rsp(exec_status, exec_addr, n_count, i_cfg.ents);
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### sv/ptt_checker.sv
// Port-level checks for the page table block, bound to the top level.
module ptt_checker import ptt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp_valid)
        else $error("result word after reset");

    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy during store clearing");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_OK) |-> o_rsp.address == '0)
        else $error("failed request with nonzero address");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.tbl_empty == (o_rsp.entry_count == '0))
        else $error("empty flag disagrees with entry count");

endmodule

bind page_table_translate ptt_checker u_ptt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

### tb/tb_page_table_translate.sv
// Self-checking testbench for the page table block: directed and random insert, remove, lookup.
module tb_page_table_translate;
    import ptt_pkg::*;

    localparam int DEPTH       = 256;
    localparam int ADDR_W      = 32;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    t_req               i_req   = '0;
    logic               o_rsp_valid;
    t_rsp               o_rsp;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [BASE_W-1:0] slot_base [DEPTH];
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  cfg_entries;
    logic [PB_W-1:0]   cfg_page_bytes;

    t_rsp expected_rsp_q [$];
    int   idle_pct;
    int   words_sent;
    int   words_checked;
    int   mismatches;
    int   settings_run;

    page_table_translate #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] live_entries();
        return (cfg_entries > DEPTH) ? 32'(DEPTH) : 32'(cfg_entries);
    endfunction

    function automatic t_rsp table_apply(t_req w);
        t_rsp        r;
        logic [31:0] ents;
        logic [31:0] page_no;
        logic [31:0] offset;
        r    = '0;
        ents = live_entries();
        case (w.req_type)
            REQ_INSERT: begin
                if (w.slot_key >= ents) begin
                    r.status = ST_KEY_RANGE;
                end else if (w.page_len != 32'(cfg_page_bytes)) begin
                    r.status = ST_BAD_SIZE;
                end else if (w.page_base == '0) begin
                    r.status = ST_NULL;
                end else if (slot_base[w.slot_key] != '0) begin
                    r.status = ST_OCCUPIED;
                end else begin
                    slot_base[w.slot_key] = w.page_base;
                    used_count = used_count + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (w.slot_key >= ents) begin
                    r.status = ST_KEY_RANGE;
                end else if (slot_base[w.slot_key] == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.address = slot_base[w.slot_key];
                    slot_base[w.slot_key] = '0;
                    used_count = used_count - 1'b1;
                end
            end
            REQ_LOOKUP: begin
                if (cfg_page_bytes == '0) begin
                    r.status = ST_LOOKUP_RANGE;
                end else begin
                    page_no = w.linear_index / 32'(cfg_page_bytes);
                    offset  = w.linear_index % 32'(cfg_page_bytes);
                    if (page_no >= ents) begin
                        r.status = ST_LOOKUP_RANGE;
                    end else begin
                        r.address = slot_base[page_no] + offset;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = used_count;
        r.is_full     = (32'(used_count) == ents);
        r.tbl_empty   = (used_count == '0);
        return r;
    endfunction

    function automatic t_req make_word(logic [REQ_W-1:0] op, logic [31:0] key,
                                       logic [31:0] base, logic [31:0] len,
                                       logic [31:0] lin);
        t_req w;
        w.req_type     = op;
        w.slot_key     = key;
        w.page_base    = base;
        w.page_len     = len;
        w.linear_index = lin;
        return w;
    endfunction

    function automatic t_req random_word();
        t_req        w;
        int unsigned sel;
        logic [31:0] ents;
        logic [31:0] pb;
        ents = live_entries();
        pb   = 32'(cfg_page_bytes);
        w    = make_word(REQ_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        sel  = $urandom_range(99);
        if (sel < 3) begin
            w.req_type = REQ_NOP;
        end else if (sel < 42) begin
            w.req_type = REQ_INSERT;
        end else if (sel < 66) begin
            w.req_type = REQ_REMOVE;
        end else begin
            w.req_type = REQ_LOOKUP;
        end
        sel = $urandom_range(9);
        if (sel == 1) begin
            w.slot_key = ents + $urandom_range(3);
        end else if (sel > 1 && ents > 0) begin
            w.slot_key = $urandom_range(ents - 1);
        end
        if ($urandom_range(19) == 0) begin
            w.page_base = '0;
        end
        sel = $urandom_range(9);
        if (sel == 1) begin
            w.page_len = pb + 1;
        end else if (sel > 1) begin
            w.page_len = pb;
        end
        if ($urandom_range(7) != 0 && pb != 0) begin
            w.linear_index = $urandom_range(ents) * pb + $urandom_range(pb - 1);
        end
        return w;
    endfunction

    task automatic send_word(t_req w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy);
        expected_rsp_q.push_back(table_apply(w));
        words_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TABLE_ENTRIES) begin
            cfg_entries = value[CNT_W-1:0];
        end else begin
            cfg_page_bytes = value[PB_W-1:0];
        end
    endtask

    task automatic set_table(int unsigned ents, int unsigned pb, int pct);
        drain();
        apb_write(REG_TABLE_ENTRIES, ents);
        apb_write(REG_PAGE_BYTES, pb);
        idle_pct = pct;
        settings_run++;
    endtask

    task automatic run_random(int n);
        repeat (n) send_word(random_word());
    endtask

    task automatic test_directed();
        idle_pct = 0;
        settings_run++;
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd0));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd5));
        send_word(make_word(REQ_REMOVE, 32'd3, '0, '0, '0));
        send_word(make_word(REQ_INSERT, 32'd0, 32'hFFFF_FFFF, 32'd4096, '0));
        send_word(make_word(REQ_INSERT, 32'd255, 32'h0000_1000, 32'd4096, '0));
        send_word(make_word(REQ_INSERT, 32'd256, 32'h1234_5678, 32'd4096, '0));
        send_word(make_word(REQ_INSERT, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, '0));
        send_word(make_word(REQ_INSERT, 32'd1, 32'h1, 32'd4095, '0));
        send_word(make_word(REQ_INSERT, 32'd1, 32'h0, 32'hFFFF_FFFF, '0));
        send_word(make_word(REQ_INSERT, 32'd1, 32'h0, 32'd4096, '0));
        send_word(make_word(REQ_INSERT, 32'd0, 32'h5555_0000, 32'd4096, '0));
        send_word(make_word(REQ_INSERT, 32'd1, 32'h8000_0000, 32'd4096, '0));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd4095));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd255 * 32'd4096 + 32'd17));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd4096 + 32'd100));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd256 * 32'd4096));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF));
        send_word(make_word(REQ_REMOVE, 32'd2, '0, '0, '0));
        send_word(make_word(REQ_REMOVE, 32'd256, '0, '0, '0));
        send_word(make_word(REQ_REMOVE, 32'hFFFF_FFFF, '0, '0, '0));
        send_word(make_word(REQ_REMOVE, 32'd0, '0, '0, '0));
        send_word(make_word(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd10));
    endtask

    task automatic test_small_table();
        set_table(8, 1, 0);
        run_random(350);
    endtask

    task automatic test_full_range();
        set_table(DEPTH, 1048576, 68);
        run_random(350);
    endtask

    task automatic test_zero_entries();
        set_table(0, 4096, 9);
        run_random(60);
    endtask

    task automatic test_odd_page();
        set_table(16, 3, 9);
        run_random(300);
    endtask

    task automatic test_zero_page();
        set_table(100, 0, 68);
        send_word(make_word(REQ_LOOKUP, '0, '0, '0, 32'd0));
        send_word(make_word(REQ_INSERT, 32'd7, 32'hABCD_0000, 32'd0, '0));
        run_random(100);
    endtask

    task automatic test_random_sizes();
        repeat (3) begin
            set_table($urandom_range(DEPTH, 1), $urandom_range(1048576, 1),
                      ($urandom_range(1) == 0) ? 0 : 68);
            run_random(150);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid === 1'b1) begin
            if (expected_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result word: status %0d addr %h count %0d",
                             o_rsp.status, o_rsp.address, o_rsp.entry_count);
                end
            end else begin
                want = expected_rsp_q.pop_front();
                words_checked++;
                if (o_rsp.status !== want.status || o_rsp.address !== want.address ||
                    o_rsp.entry_count !== want.entry_count ||
                    o_rsp.is_full !== want.is_full || o_rsp.tbl_empty !== want.tbl_empty) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch on result %0d: exp st %0d addr %h cnt %0d f %b e %b",
                                 words_checked, want.status, want.address,
                                 want.entry_count, want.is_full, want.tbl_empty);
                        $display("                       got st %0d addr %h cnt %0d f %b e %b",
                                 o_rsp.status, o_rsp.address, o_rsp.entry_count,
                                 o_rsp.is_full, o_rsp.tbl_empty);
                    end
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAIL page_table_translate");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_base[i] = '0;
        end
        used_count     = '0;
        cfg_entries    = TABLE_ENTRIES_RST;
        cfg_page_bytes = PAGE_BYTES_RST;
        idle_pct       = 0;
        words_sent     = 0;
        words_checked  = 0;
        mismatches     = 0;
        settings_run   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_small_table();
        test_full_range();
        test_zero_entries();
        test_odd_page();
        test_zero_page();
        test_random_sizes();
        drain();

        mismatches += expected_rsp_q.size();
        $display("sent %0d request words under %0d table settings, checked %0d results",
                 words_sent, settings_run, words_checked);
        $display("settings spanned 0..%0d entries and page sizes 0..1048576, idle 0/9/68",
                 DEPTH);
        if (mismatches == 0) begin
            $display("PASS page_table_translate");
        end else begin
            $display("%0d failures", mismatches);
            $display("FAIL page_table_translate");
        end
        $finish;
    end

endmodule
